>>> hw/rtl/hex_hit_stream_decoder_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the hex hit stream decoder
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef HEX_HIT_STREAM_DECODER_MACROS_SVH
`define HEX_HIT_STREAM_DECODER_MACROS_SVH

// Check that a property holds at every clock edge outside reset
`define HHSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never occurs outside reset
`define HHSD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> hw/rtl/hhsd_pkg.sv
// ----------------------------------------------------------------------------
// hhsd_pkg
// Shared constants and types of the hex hit stream decoder.
// ----------------------------------------------------------------------------
package hhsd_pkg;

  localparam int HIT_BYTES   = 5;
  localparam int DEC_BYTES   = 5;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_NULL  = 8'h66;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LOW_B = 8'h62;
  localparam logic [7:0] CH_LOW_C = 8'h63;

  localparam logic [7:0] PERIOD_RESET = 8'd5;

  localparam int OUT_BITS  = 87;
  localparam int OUT_BYTES = (OUT_BITS + 7) / 8;
  localparam int OUT_W     = OUT_BYTES * 8;

  typedef struct packed {
    logic [31:0]                line_index;
    logic [DEC_BYTES-1:0][7:0] raw_bytes;
  } hit_req_t;

endpackage

>>> hw/rtl/hhsd_front.sv
// ----------------------------------------------------------------------------
// hhsd_front
// Character intake: line framing, sliding window and hit classification.
// ----------------------------------------------------------------------------
module hhsd_front #(
  parameter int HitBytes = hhsd_pkg::HIT_BYTES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [7:0]         s_axis_tdata_i,   // char_code[7:0]
  output logic               req_valid_o,
  output hhsd_pkg::hit_req_t req_o,
  input  logic               q_ready_i
);
  import hhsd_pkg::*;

  localparam int WinChars = 2 * HitBytes;
  localparam int FillW    = $clog2(WinChars + 1);
  localparam int IdxW     = $clog2(WinChars);

  logic [7:0]       win_q [WinChars];
  logic [7:0]       win_d [WinChars];
  logic [FillW-1:0] fill_q, fill_d;
  logic             frame_q, frame_d;
  logic [31:0]      line_q, line_d;

  logic accept;
  logic shift_en;
  logic starts20;
  logic heartbeat;
  logic all_hex;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_nib(input logic [7:0] c);
    logic [3:0] n;
    n = (c <= 8'h39) ? c[3:0] : 4'(c[3:0] + 4'd9);
    return n;
  endfunction

  assign s_axis_tready_o = q_ready_i;
  assign accept   = s_axis_tvalid_i && q_ready_i;
  assign shift_en = accept && frame_q && (s_axis_tdata_i != CH_NULL) &&
                    (s_axis_tdata_i != CH_QUOTE);

  always_comb begin
    win_d   = win_q;
    fill_d  = fill_q;
    frame_d = frame_q;
    line_d  = line_q;
    if (accept && s_axis_tdata_i == CH_QUOTE) begin
      if (frame_q) begin
        line_d = line_q + 32'd1;
      end
      frame_d = !frame_q;
      fill_d  = '0;
    end else if (shift_en) begin
      if (fill_q < FillW'(WinChars)) begin
        win_d[fill_q[IdxW-1:0]] = s_axis_tdata_i;
        fill_d = fill_q + 1'b1;
      end else begin
        for (int i = 0; i < WinChars - 1; i++) begin
          win_d[i] = win_q[i+1];
        end
        win_d[WinChars-1] = s_axis_tdata_i;
      end
    end
  end

  always_comb begin
    starts20  = (win_d[0] == CH_TWO) && (win_d[1] == CH_ZERO);
    heartbeat = 1'b0;
    all_hex   = 1'b1;
    for (int i = 0; i + 4 <= WinChars; i++) begin
      if (win_d[i] == CH_LOW_B && win_d[i+1] == CH_LOW_C &&
          win_d[i+2] == CH_LOW_B && win_d[i+3] == CH_LOW_C) begin
        heartbeat = 1'b1;
      end
    end
    for (int i = 0; i < WinChars; i++) begin
      if (!is_hex(win_d[i])) begin
        all_hex = 1'b0;
      end
    end
  end

  assign req_valid_o = shift_en && (fill_d == FillW'(WinChars)) && starts20 &&
                       !heartbeat && all_hex;

  always_comb begin
    req_o.line_index = line_q;
    for (int i = 0; i < DEC_BYTES; i++) begin
      req_o.raw_bytes[i] = {hex_nib(win_d[2*i]), hex_nib(win_d[2*i+1])};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      frame_q <= 1'b0;
      line_q  <= '0;
    end else begin
      fill_q  <= fill_d;
      frame_q <= frame_d;
      line_q  <= line_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

endmodule

>>> hw/rtl/hhsd_fifo.sv
// ----------------------------------------------------------------------------
// hhsd_fifo
// Short request queue between the intake and the decode stage.
// ----------------------------------------------------------------------------
`include "hex_hit_stream_decoder_macros.svh"

module hhsd_fifo #(
  parameter int Depth = hhsd_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  hhsd_pkg::hit_req_t push_data_i,
  output logic               ready_o,
  output logic               valid_o,
  output hhsd_pkg::hit_req_t pop_data_o,
  input  logic               pop_i
);
  import hhsd_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  hit_req_t        mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] count_q, count_d;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : PtrW'(p + 1'b1);
  endfunction

  assign ready_o    = (count_q != CntW'(Depth));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    wr_d    = push_i ? ptr_next(wr_q) : wr_q;
    rd_d    = pop_i ? ptr_next(rd_q) : rd_q;
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  `HHSD_ASSERT(a_count_bound, count_q <= CntW'(Depth), "queue count beyond depth")
  `HHSD_ASSERT_NEVER(a_no_overflow, push_i && !ready_o, "request pushed into full queue")
  `HHSD_ASSERT_NEVER(a_no_underflow, pop_i && !valid_o, "request popped from empty queue")
  `HHSD_ASSERT(a_count_up, (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1), "queue count did not advance")

endmodule

>>> hw/rtl/hhsd_back.sv
// ----------------------------------------------------------------------------
// hhsd_back
// Hit decode: bit reversal, field extraction, ToT scaling, output register.
// ----------------------------------------------------------------------------
module hhsd_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [7:0]                 cfg_wdata_i,
  input  logic                       req_valid_i,
  input  hhsd_pkg::hit_req_t         req_i,
  output logic                       req_pop_o,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  output logic [hhsd_pkg::OUT_W-1:0] m_axis_tdata_o
);
  import hhsd_pkg::*;

  logic [7:0]       period_q;
  logic             out_valid_q;
  logic [OUT_W-1:0] out_data_q, out_data_d;

  logic [DEC_BYTES-1:0][7:0] rev;
  logic [11:0]               tot;
  logic [19:0]               tot_ns;

  function automatic logic [7:0] flip8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

  always_comb begin
    for (int i = 0; i < DEC_BYTES; i++) begin
      rev[i] = flip8(req_i.raw_bytes[i]);
    end
  end

  assign tot    = {rev[3][3:0], rev[4]};
  assign tot_ns = 20'(tot) * 20'(period_q);

  assign out_data_d = {{(OUT_W - OUT_BITS){1'b0}}, tot_ns, tot, rev[2], rev[1][7],
                       rev[1][5:0], rev[0][2:0], rev[0][7:3], req_i.line_index};

  assign req_pop_o       = req_valid_i && (!out_valid_q || m_axis_tready_i);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= PERIOD_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        period_q <= cfg_wdata_i;
      end
      if (req_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_pop_o) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

>>> hw/rtl/hex_hit_stream_decoder.sv
// ----------------------------------------------------------------------------
// hex_hit_stream_decoder
// A hit goes through the request queue, then the output register, to m_axis.
// Throughput: one character per cycle, sustained while m_axis drains.
// Input stalls only when the two-entry request queue is full.
// Reset clears framing, window fill, line count, queue and output valid;
// the sample period returns to 5 ns.
// ----------------------------------------------------------------------------
module hex_hit_stream_decoder #(
  parameter int HitBytes   = hhsd_pkg::HIT_BYTES,
  parameter int QueueDepth = hhsd_pkg::QUEUE_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [7:0]                 cfg_wdata_i,    // sample_period_ns[7:0]
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,   // char_code[7:0]
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // line_index[31:0], chip_id[36:32], payload[39:37], location[45:40],
  // is_column[46], timestamp[54:47], tot_count[66:55], tot_ns[86:67], zero[87]
  output logic [hhsd_pkg::OUT_W-1:0] m_axis_tdata
);
  import hhsd_pkg::*;

  logic     push;
  hit_req_t push_data;
  logic     q_ready;
  logic     q_valid;
  hit_req_t q_data;
  logic     q_pop;

  hhsd_front #(
    .HitBytes(HitBytes)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .req_valid_o    (push),
    .req_o          (push_data),
    .q_ready_i      (q_ready)
  );

  hhsd_fifo #(
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .ready_o    (q_ready),
    .valid_o    (q_valid),
    .pop_data_o (q_data),
    .pop_i      (q_pop)
  );

  hhsd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .req_valid_i    (q_valid),
    .req_i          (q_data),
    .req_pop_o      (q_pop),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata)
  );

endmodule
